[design/gcb_pkg.sv]
// Shared types and constants for the graph coloring backtracking search block.
package gcb_pkg;

  // Fixed field widths
  localparam int MASK_W  = 8;
  localparam int INDEX_W = 3;
  localparam int COLOR_W = 2;
  localparam int NCOL_W  = 3;

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-3:0]  REG_NUM_COLORS   = 1'b0;
  localparam logic [NCOL_W-1:0]   NUM_COLORS_RESET = 3'd3;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_SEARCH,
    ST_EMIT_OK,
    ST_EMIT_FAIL
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic store_row;
    logic start;
    logic place;
    logic next_cand;
    logic backtrack;
    logic emit_start;
    logic emit_ok;
    logic emit_fail;
    logic finish;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic depth_done;
    logic cand_ok;
    logic fits;
    logic depth_zero;
    logic emit_last;
    logic out_free;
  } stat_t;

endpackage

[design/gcb_in_if.sv]
// Input channel interface: one neighbor-mask row per transaction.
interface gcb_in_if;
  logic                        valid;
  logic                        ready;
  logic [gcb_pkg::MASK_W-1:0]  neighbor_mask;
  logic                        last_vertex;

  modport source (output valid, output neighbor_mask, output last_vertex, input ready);
  modport sink   (input valid, input neighbor_mask, input last_vertex, output ready);
endinterface

[design/gcb_out_if.sv]
// Output channel interface: one vertex color result per transaction.
interface gcb_out_if;
  logic                         valid;
  logic                         ready;
  logic                         solved;
  logic [gcb_pkg::INDEX_W-1:0]  vertex_index;
  logic [gcb_pkg::COLOR_W-1:0]  vertex_color;
  logic                         last_result;

  modport source (output valid, output solved, output vertex_index, output vertex_color,
                  output last_result, input ready);
  modport sink   (input valid, input solved, input vertex_index, input vertex_color,
                  input last_result, output ready);
endinterface

[design/gcb_regs.sv]
// APB-style configuration register holding the number of colors.
module gcb_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gcb_pkg::PADDR_W-1:0]  paddr,
  input  logic [gcb_pkg::PDATA_W-1:0]  pwdata,
  output logic [gcb_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [gcb_pkg::NCOL_W-1:0]   num_colors
);
  import gcb_pkg::*;

  logic hit;

  // Decode the register index from the word address
  assign hit    = (paddr[PADDR_W-1:2] == REG_NUM_COLORS);
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_colors <= NUM_COLORS_RESET;
    end else if (psel && penable && pwrite && hit) begin
      num_colors <= pwdata[NCOL_W-1:0];
    end
  end

  // Return the register value, zero elsewhere
  assign prdata = hit ? PDATA_W'(num_colors) : '0;

endmodule

[design/gcb_ctrl.sv]
// Controller state machine: row loading, search stepping, result emission.
module gcb_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  logic            in_last,
  output logic            in_ready,
  input  gcb_pkg::stat_t  stat,
  output gcb_pkg::cmd_t   cmd
);
  import gcb_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_LOAD: begin
        // Take rows; the marked row launches the search
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.store_row = 1'b1;
          if (in_last) begin
            cmd.start  = 1'b1;
            state_next = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        // One candidate test, placement or backtrack per cycle
        if (stat.depth_done) begin
          cmd.emit_start = 1'b1;
          state_next     = ST_EMIT_OK;
        end else if (stat.cand_ok && stat.fits) begin
          cmd.place = 1'b1;
        end else if (stat.cand_ok) begin
          cmd.next_cand = 1'b1;
        end else if (stat.depth_zero) begin
          state_next = ST_EMIT_FAIL;
        end else begin
          cmd.backtrack = 1'b1;
        end
      end
      ST_EMIT_OK: begin
        // Push one vertex color whenever the output register frees up
        if (stat.out_free) begin
          cmd.emit_ok = 1'b1;
          if (stat.emit_last) begin
            cmd.finish = 1'b1;
            state_next = ST_LOAD;
          end
        end
      end
      ST_EMIT_FAIL: begin
        if (stat.out_free) begin
          cmd.emit_fail = 1'b1;
          cmd.finish    = 1'b1;
          state_next    = ST_LOAD;
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

endmodule

[design/gcb_datapath.sv]
// Datapath: adjacency rows, color stack, candidate check and output register.
module gcb_datapath #(
  parameter int MAX_VERTICES = 8,
  parameter int MAX_COLORS   = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  input  gcb_pkg::cmd_t                cmd,
  output gcb_pkg::stat_t               stat,
  input  logic [gcb_pkg::MASK_W-1:0]   neighbor_mask,
  input  logic [gcb_pkg::NCOL_W-1:0]   num_colors,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_solved,
  output logic [gcb_pkg::INDEX_W-1:0]  out_vertex_index,
  output logic [gcb_pkg::COLOR_W-1:0]  out_vertex_color,
  output logic                         out_last_result
);
  import gcb_pkg::*;

  localparam int DW   = $clog2(MAX_VERTICES + 1);
  localparam int AW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW   = (MAX_COLORS > 1) ? $clog2(MAX_COLORS) : 1;
  localparam int CAW  = $clog2(MAX_COLORS + 1);
  localparam int CMPW = (CAW > NCOL_W) ? CAW : NCOL_W;
  localparam int PADW = (MAX_VERTICES > MASK_W) ? MAX_VERTICES : MASK_W;

  logic [MASK_W-1:0] rows   [MAX_VERTICES];
  logic [CW-1:0]     choice [MAX_VERTICES];
  logic [DW-1:0]     count;
  logic [DW-1:0]     depth;
  logic [CAW-1:0]    cand;

  logic [DW-1:0]     depth_m1;
  logic [AW-1:0]     cur_idx;
  logic [AW-1:0]     rd_idx;
  logic [CW-1:0]     choice_rd;
  logic [PADW-1:0]   row_pad;
  logic              count_room;
  logic              conflict;
  logic [CMPW-1:0]   ncol;
  logic [DW+2:0]     depth_wide;
  logic [CW+1:0]     color_wide;

  assign depth_m1   = depth - DW'(1);
  assign cur_idx    = depth[AW-1:0];
  assign rd_idx     = cmd.backtrack ? depth_m1[AW-1:0] : depth[AW-1:0];
  assign choice_rd  = choice[rd_idx];
  assign row_pad    = PADW'(rows[cur_idx]);
  assign count_room = (count < DW'(MAX_VERTICES));
  assign depth_wide = (DW + 3)'(depth);
  assign color_wide = (CW + 2)'(choice_rd);

  // Clamp the color count to the supported maximum
  assign ncol = (CMPW'(num_colors) > CMPW'(MAX_COLORS)) ? CMPW'(MAX_COLORS)
                                                        : CMPW'(num_colors);

  // Check the candidate against every earlier neighbor in the current row
  always_comb begin
    conflict = 1'b0;
    for (int j = 0; j < MAX_VERTICES; j++) begin
      if ((DW'(j) < depth) && row_pad[j] && (choice[j] == cand[CW-1:0])) begin
        conflict = 1'b1;
      end
    end
  end

  assign stat.depth_done = (depth >= count);
  assign stat.cand_ok    = (CMPW'(cand) < ncol);
  assign stat.fits       = !conflict;
  assign stat.depth_zero = (depth == '0);
  assign stat.emit_last  = ((DW + 1)'(depth) + (DW + 1)'(1)) == (DW + 1)'(count);
  assign stat.out_free   = !out_valid || out_ready;

  // Storage and output payload
  always_ff @(posedge clk) begin
    if (cmd.store_row && count_room) begin
      rows[count[AW-1:0]] <= neighbor_mask;
    end
    if (cmd.place) begin
      choice[cur_idx] <= cand[CW-1:0];
    end
    if (cmd.emit_ok) begin
      out_solved       <= 1'b1;
      out_vertex_index <= depth_wide[INDEX_W-1:0];
      out_vertex_color <= color_wide[COLOR_W-1:0];
      out_last_result  <= stat.emit_last;
    end else if (cmd.emit_fail) begin
      out_solved       <= 1'b0;
      out_vertex_index <= '0;
      out_vertex_color <= '0;
      out_last_result  <= 1'b1;
    end
  end

  // Row count, stack depth, candidate color and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      depth     <= '0;
      cand      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.finish) begin
        count <= '0;
      end else if (cmd.store_row && count_room) begin
        count <= count + DW'(1);
      end

      if (cmd.finish || cmd.start || cmd.emit_start) begin
        depth <= '0;
      end else if (cmd.place || cmd.emit_ok) begin
        depth <= depth + DW'(1);
      end else if (cmd.backtrack) begin
        depth <= depth_m1;
      end

      if (cmd.start || cmd.place) begin
        cand <= '0;
      end else if (cmd.next_cand) begin
        cand <= cand + CAW'(1);
      end else if (cmd.backtrack) begin
        cand <= CAW'(choice_rd) + CAW'(1);
      end

      if (cmd.emit_ok || cmd.emit_fail) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[design/graph_coloring_backtrack_top.sv]
// Top level of the graph coloring backtracking search block.
//
// Usage: write num_colors over the APB port (byte address 0) while idle, then
// send the graph on in_ch, one neighbor-mask row per transaction, vertex 0
// first. Up to MAX_VERTICES rows are stored; further rows are dropped. The row
// with last_vertex set starts a depth-first search that tries colors in
// ascending order for vertices in index order.
// Throughput: rows load at one per cycle. The search advances one step per
// cycle (one candidate test, placement or backtrack through the color stack),
// so its length depends on the graph.
// Results: on success one transaction per vertex with its color, last_result
// on the final one, at most one per cycle; on failure a single transaction with
// solved cleared. in_ch is not ready from the last row until the final result
// sits in the output register. A stalled out_ch holds the output register and
// the emission of the remaining results waits. Reset (rst, synchronous) empties
// the graph, drops any pending result and sets num_colors to 3.
module graph_coloring_backtrack_top #(
  parameter int MAX_VERTICES = 8,
  parameter int MAX_COLORS   = 4
) (
  input  logic                         clk,
  input  logic                         rst,
  gcb_in_if.sink                       in_ch,
  gcb_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [gcb_pkg::PADDR_W-1:0]  paddr,
  input  logic [gcb_pkg::PDATA_W-1:0]  pwdata,
  output logic [gcb_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);
  import gcb_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [NCOL_W-1:0] num_colors;

  gcb_regs u_regs (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .num_colors (num_colors)
  );

  gcb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_last  (in_ch.last_vertex),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gcb_datapath #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_COLORS   (MAX_COLORS)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .neighbor_mask    (in_ch.neighbor_mask),
    .num_colors       (num_colors),
    .out_ready        (out_ch.ready),
    .out_valid        (out_ch.valid),
    .out_solved       (out_ch.solved),
    .out_vertex_index (out_ch.vertex_index),
    .out_vertex_color (out_ch.vertex_color),
    .out_last_result  (out_ch.last_result)
  );

endmodule
